### rtl/imu_angle_frame_deframer_macros.svh
// Assertion macros for the IMU angle frame deframer checker.
// Needs clk and arst_n in scope at the point of use.
`ifndef IMU_ANGLE_FRAME_DEFRAMER_MACROS_SVH
`define IMU_ANGLE_FRAME_DEFRAMER_MACROS_SVH

// Condition holds at every edge out of reset.
`define IAFD_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent holds at the same edge as the antecedent.
`define IAFD_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds at the edge after the antecedent.
`define IAFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/iafd_pkg.sv
// Shared types and constants for the IMU angle frame deframer.
// No dependencies.
package iafd_pkg;

	localparam int unsigned FRAME_LEN = 14;
	localparam int unsigned HOLD_LEN  = 13;
	localparam int unsigned CNT_W     = 4;
	localparam int unsigned LIMIT_W   = 31;
	localparam int unsigned ANGLE_W   = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'h4120_0000;
	localparam logic [CNT_W-1:0]   CNT_FULL    = 4'd13;
	localparam logic [7:0]         TRAILER_BYTE = 8'h00;

	typedef logic [7:0] byte_t;

	typedef enum logic {
		ST_HUNT,
		ST_LOCK
	} sync_state_t;

	// Decision from the control cell for the current byte.
	typedef struct packed {
		logic shift;     // item accepted, advance the chain
		logic frame_ok;  // full frame with a zero trailer present
	} ctrl_t;

endpackage

### rtl/iafd_cell.sv
// One byte cell of the deframer's shift chain.
// Depends on iafd_pkg.
module iafd_cell
	import iafd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  byte_t d,
	output byte_t q
);

	byte_t byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

### rtl/iafd_ctrl.sv
// Sync tracking and byte count for the deframer.
// Depends on iafd_pkg.
module iafd_ctrl
	import iafd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  logic  trailer_zero,
	output ctrl_t ctrl
);

	sync_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic full;

	assign full = (cnt_q == CNT_FULL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ctrl.shift    = accept;
		ctrl.frame_ok = accept && full && trailer_zero;
		if (accept) begin
			case (state_q)
				ST_HUNT: begin
					if (!full) begin
						cnt_d = cnt_q + 1'b1;
					end else if (trailer_zero) begin
						state_d = ST_LOCK;
						cnt_d   = '0;
					end
				end
				ST_LOCK: begin
					if (!full) begin
						cnt_d = cnt_q + 1'b1;
					end else if (trailer_zero) begin
						cnt_d = '0;
					end else begin
						// trailer lost: the chain already holds the last 13 bytes
						state_d = ST_HUNT;
						cnt_d   = CNT_FULL;
					end
				end
				default: begin
					state_d = ST_HUNT;
					cnt_d   = '0;
				end
			endcase
		end
	end

endmodule

### rtl/imu_angle_frame_deframer.sv
// Top level of the IMU angle frame deframer: byte chain, control and output register.
// Depends on iafd_pkg, iafd_cell and iafd_ctrl.

// Takes one byte per clock unless stalled and finds 14-byte frames ending in two
// zero bytes, giving yaw, pitch and roll as IEEE-754 single bit patterns when
// every magnitude is at or below the limit (reset 10.0). The bytes pass through
// a row of 13 byte cells that always hold the last 13 bytes received, so the
// chain never stalls input; a frame is output in the cycle after its last byte.
// A single output register parts the two sides: in_ready is low only while a
// result waits and out_ready is low. Write the limit only while idle.
module imu_angle_frame_deframer
	import iafd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ANGLE_W-1:0] yaw_bits,
	output logic [ANGLE_W-1:0] pitch_bits,
	output logic [ANGLE_W-1:0] roll_bits,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata
);

	byte_t chain [HOLD_LEN];
	byte_t chain_d [HOLD_LEN];
	ctrl_t ctrl;
	logic accept, trailer_zero, angles_ok;
	logic [LIMIT_W-1:0] limit_q;
	logic [ANGLE_W-1:0] yaw_w, pitch_w, roll_w;
	logic out_valid_q;
	logic [ANGLE_W-1:0] yaw_q, pitch_q, roll_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// oldest byte in cell 0, newest enters at the far end
	for (genvar i = 0; i < HOLD_LEN; i++) begin : g_cell
		if (i == HOLD_LEN - 1) begin : g_last
			assign chain_d[i] = rx_byte;
		end else begin : g_mid
			assign chain_d[i] = chain[i+1];
		end
		iafd_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (ctrl.shift),
			.d      (chain_d[i]),
			.q      (chain[i])
		);
	end

	assign trailer_zero = (chain[HOLD_LEN-1] == TRAILER_BYTE) && (rx_byte == TRAILER_BYTE);

	iafd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.trailer_zero (trailer_zero),
		.ctrl         (ctrl)
	);

	assign yaw_w   = {chain[3], chain[2], chain[1], chain[0]};
	assign pitch_w = {chain[7], chain[6], chain[5], chain[4]};
	assign roll_w  = {chain[11], chain[10], chain[9], chain[8]};

	// compare magnitudes only, sign bit dropped
	assign angles_ok = (yaw_w[LIMIT_W-1:0] <= limit_q)
		&& (pitch_w[LIMIT_W-1:0] <= limit_q)
		&& (roll_w[LIMIT_W-1:0] <= limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= ctrl.frame_ok && angles_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && ctrl.frame_ok && angles_ok) begin
			yaw_q   <= yaw_w;
			pitch_q <= pitch_w;
			roll_q  <= roll_w;
		end
	end

	assign out_valid  = out_valid_q;
	assign yaw_bits   = yaw_q;
	assign pitch_bits = pitch_q;
	assign roll_bits  = roll_q;

endmodule

### rtl/iafd_checker.sv
// Port-level checks for the IMU angle frame deframer, bound to the top level.
// Depends on iafd_pkg and imu_angle_frame_deframer_macros.svh.
`include "imu_angle_frame_deframer_macros.svh"

module iafd_checker
	import iafd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [ANGLE_W-1:0] yaw_bits,
	input logic [ANGLE_W-1:0] pitch_bits,
	input logic [ANGLE_W-1:0] roll_bits
);

	// a waiting result holds its value until taken
	`IAFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(yaw_bits) && $stable(pitch_bits) && $stable(roll_bits), "result dropped or changed while stalled")

	// an empty output stage never blocks the input
	`IAFD_ASSERT_IMPLY(a_ready_when_empty, !out_valid, in_ready, "input stalled with no result waiting")

	// a new result only follows an accepted byte
	`IAFD_ASSERT_IMPLY(a_result_from_item, $rose(out_valid), $past(in_valid && in_ready), "result appeared without an accepted item")

	// a stalled result blocks further input
	`IAFD_ASSERT_ALWAYS(a_block_when_full, !(out_valid && !out_ready && in_ready), "input taken while a result is stalled")

endmodule

bind imu_angle_frame_deframer iafd_checker u_iafd_checker (.*);

### verif/tb_imu_angle_frame_deframer.sv
// Self-checking testbench for imu_angle_frame_deframer: byte stream in, angle triples out.
// Depends on iafd_pkg and the deframer RTL; predicts frames on its own and checks them in order.
module tb_imu_angle_frame_deframer;
	import iafd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 7;
	localparam int SETTLE       = 4;
	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_BYTES  = 260;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [ANGLE_W-1:0] yaw;
		logic [ANGLE_W-1:0] pitch;
		logic [ANGLE_W-1:0] roll;
	} angles_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         rx_byte = 8'h00;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [ANGLE_W-1:0] yaw_bits;
	logic [ANGLE_W-1:0] pitch_bits;
	logic [ANGLE_W-1:0] roll_bits;
	logic               cfg_we = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;

	byte_t   rx_pending_q[$];
	angles_t frame_expect_q[$];

	// Deframer state as seen from outside
	byte_t              held [HOLD_LEN] = '{default: 8'h00};
	logic [CNT_W-1:0]   held_cnt = '0;
	sync_state_t        sync_st = ST_HUNT;
	logic [LIMIT_W-1:0] limit_model = LIMIT_RESET;

	bit byte_taken = 1'b0;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_cycles = 0;
	int fault_count = 0;

	imu_angle_frame_deframer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.yaw_bits  (yaw_bits),
		.pitch_bits(pitch_bits),
		.roll_bits (roll_bits),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Advance the frame tracker by one byte and queue the angles it releases, if any.
	function automatic void deframe_byte(input byte_t b);
		byte_t              frame [FRAME_LEN];
		logic [ANGLE_W-1:0] ang;
		bit                 pass;
		angles_t            got;
		for (int i = 0; i < HOLD_LEN; i++)
			frame[i] = held[i];
		frame[HOLD_LEN] = b;
		if (held_cnt < CNT_FULL) begin
			held[held_cnt] = b;
			held_cnt++;
		end else if (frame[HOLD_LEN-1] != TRAILER_BYTE || b != TRAILER_BYTE) begin
			// Bad trailer: drop sync if held, keep the newest 13 bytes and slide on
			for (int i = 0; i < HOLD_LEN; i++)
				held[i] = frame[i+1];
			sync_st = ST_HUNT;
		end else begin
			sync_st  = ST_LOCK;
			held_cnt = '0;
			pass     = 1'b1;
			for (int k = 0; k < 3; k++) begin
				ang = {frame[4*k+3], frame[4*k+2], frame[4*k+1], frame[4*k]};
				if (ang[LIMIT_W-1:0] > limit_model)
					pass = 1'b0;
				got = {got[2*ANGLE_W-1:0], ang};
			end
			if (pass)
				frame_expect_q.push_back(got);
		end
	endfunction

	function automatic void note_fault(input string msg);
		if (fault_count < REPORT_MAX)
			$display("%0t ns: %s", $realtime, msg);
		fault_count++;
	endfunction

	function automatic void push_frame(input logic [ANGLE_W-1:0] y, input logic [ANGLE_W-1:0] p,
			input logic [ANGLE_W-1:0] r, input byte_t t12, input byte_t t13);
		for (int k = 0; k < 4; k++)
			rx_pending_q.push_back(y[8*k +: 8]);
		for (int k = 0; k < 4; k++)
			rx_pending_q.push_back(p[8*k +: 8]);
		for (int k = 0; k < 4; k++)
			rx_pending_q.push_back(r[8*k +: 8]);
		rx_pending_q.push_back(t12);
		rx_pending_q.push_back(t13);
	endfunction

	// Pick an angle near the interesting points of the current limit.
	function automatic logic [ANGLE_W-1:0] pick_angle(input logic [LIMIT_W-1:0] lim,
			input bit must_pass);
		logic               s;
		logic [LIMIT_W-1:0] m;
		int                 kind;
		s    = 1'($urandom_range(1, 0));
		kind = must_pass ? $urandom_range(2, 0) : $urandom_range(7, 0);
		case (kind)
			0: m = lim;
			1: m = '0;
			2: m = LIMIT_W'($urandom_range(lim, 0));
			3: m = (lim == '1) ? lim : lim + 1'b1;
			4: m = 31'h7F80_0000;
			5: m = 31'h7F80_0000 | LIMIT_W'($urandom_range(32'h007F_FFFF, 1));
			default: m = LIMIT_W'($urandom);
		endcase
		return {s, m};
	endfunction

	task automatic queue_random_traffic(input int n_bytes, input logic [LIMIT_W-1:0] lim);
		int    queued = 0;
		int    pick;
		int    n;
		bit    clean;
		byte_t t12;
		byte_t t13;
		while (queued < n_bytes) begin
			pick = $urandom_range(99, 0);
			if (pick < 8) begin
				// Line noise, rich in zeros to provoke false locks
				n = $urandom_range(5, 1);
				for (int i = 0; i < n; i++)
					rx_pending_q.push_back($urandom_range(1, 0) ? 8'h00 : 8'($urandom));
				queued += n;
			end else if (pick < 18) begin
				t12 = 8'($urandom);
				t13 = 8'($urandom);
				case ($urandom_range(2, 0))
					0: begin t12 = TRAILER_BYTE; t13 = t13 | (8'h01 << $urandom_range(7, 0)); end
					1: begin t13 = TRAILER_BYTE; t12 = t12 | (8'h01 << $urandom_range(7, 0)); end
					default: t12 = t12 | 8'h80;
				endcase
				push_frame(pick_angle(lim, 1'b0), pick_angle(lim, 1'b0), pick_angle(lim, 1'b0),
					t12, t13);
				queued += FRAME_LEN;
			end else begin
				clean = ($urandom_range(99, 0) < 60);
				push_frame(pick_angle(lim, clean), pick_angle(lim, clean), pick_angle(lim, clean),
					TRAILER_BYTE, TRAILER_BYTE);
				queued += FRAME_LEN;
			end
		end
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		@(negedge clk);
		cfg_wdata   <= value;
		cfg_we      <= 1'b1;
		limit_model = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every queued byte is in and every expected frame is out, then let the pipe drain.
	task automatic wait_quiet();
		while (rx_pending_q.size() != 0 || in_valid || frame_expect_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n && !(in_valid && !byte_taken)) begin
			if (rx_pending_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				rx_byte  <= rx_pending_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : port_watch
		angles_t seen;
		angles_t want;
		bit      result_taken;
		if (arst_n) begin
			byte_taken   = in_valid && in_ready;
			result_taken = out_valid && out_ready;
			if (byte_taken)
				deframe_byte(rx_byte);
			if (result_taken) begin
				seen = {yaw_bits, pitch_bits, roll_bits};
				if (frame_expect_q.size() == 0) begin
					note_fault($sformatf("unexpected frame: yaw %h pitch %h roll %h",
						seen.yaw, seen.pitch, seen.roll));
				end else begin
					want = frame_expect_q.pop_front();
					if (seen !== want)
						note_fault($sformatf({"frame mismatch: expected yaw %h pitch %h roll %h,",
							" got yaw %h pitch %h roll %h"}, want.yaw, want.pitch, want.roll,
							seen.yaw, seen.pitch, seen.roll));
				end
			end
			if (byte_taken || result_taken)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("imu_angle_frame_deframer regression: fail");
				$finish;
			end
		end
	end

	initial begin
		logic [LIMIT_W-1:0] lim;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 6;
		recv_idle_pct = 77;
		@(posedge clk);
		// Fill then lock straight away; every magnitude is at or below the default limit
		push_frame(32'h4120_0000, 32'hC120_0000, 32'h8000_0000, TRAILER_BYTE, TRAILER_BYTE);
		// Locked frame with angles just over the limit, infinity and NaN: nothing out
		push_frame(32'h4120_0001, 32'h7F80_0000, 32'hFFFF_FFFF, TRAILER_BYTE, TRAILER_BYTE);
		// Trailer lost: drop sync and start sliding
		push_frame(32'h0000_0000, 32'h3F80_0000, 32'hBF80_0000, TRAILER_BYTE, 8'hFF);
		wait_quiet();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: lim = 31'h7F80_0000;
				1: lim = '0;
				2: lim = LIMIT_W'($urandom_range(32'h7F80_0000, 0));
				3: lim = LIMIT_RESET;
				4: lim = 31'h3F80_0000;
				default: lim = LIMIT_W'($urandom_range(32'h7F80_0000, 0));
			endcase
			if (ph == 2) begin
				send_idle_pct = 77;
				recv_idle_pct = 6;
			end else if (ph == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_limit(lim);
			@(posedge clk);
			// Starve the output while bytes keep coming so the input backs up
			if (ph == 4)
				hold_request = 1'b1;
			queue_random_traffic(PHASE_BYTES, lim);
			wait_quiet();
		end
		if (fault_count == 0)
			$display("imu_angle_frame_deframer regression: pass");
		else
			$display("imu_angle_frame_deframer regression: fail");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/iafd_pkg.sv
rtl/iafd_cell.sv
rtl/iafd_ctrl.sv
rtl/imu_angle_frame_deframer.sv
rtl/iafd_checker.sv
verif/tb_imu_angle_frame_deframer.sv
